// File: rtl/core/assert_macros.svh
// Assertion macros shared by the RTL of the markup stripping block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check a property on the rising clock edge, switched off while reset is asserted.
`define ASSERT_RST(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Check a property on every rising clock edge, reset included.
`define ASSERT_CLK(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_RST(label, clk, rstn, prop, msg)
`define ASSERT_CLK(label, clk, prop, msg)
`endif
`endif

// File: rtl/core/mse_pkg.sv
// Types, codes and the entity table of the markup stripping block.
`default_nettype none
package mse_pkg;

    localparam int EntCount  = 5;
    localparam int EntHold   = 5;
    localparam int EntMaxLen = 6;

    typedef logic [7:0]  byte_t;
    typedef logic [2:0]  fill_t;
    typedef logic [2:0]  bidx_t;
    typedef logic [1:0]  kind_t;
    typedef logic [15:0] occ_t;

    // Input item kinds
    localparam kind_t KIND_TEXT       = 2'd0;
    localparam kind_t KIND_CHUNK_END  = 2'd1;
    localparam kind_t KIND_ELEM_START = 2'd2;
    localparam kind_t KIND_ELEM_END   = 2'd3;

    // Characters with a meaning of their own
    localparam byte_t CH_AMP = 8'h26;
    localparam byte_t CH_LT  = 8'h3C;
    localparam byte_t CH_GT  = 8'h3E;
    localparam byte_t CH_NL  = 8'h0A;

    // Entity spellings, padded with zeros past their length
    localparam byte_t EntText [EntCount][EntMaxLen] = '{
        '{"&", "a", "m", "p", ";", 8'h00},
        '{"&", "g", "t", ";", 8'h00, 8'h00},
        '{"&", "l", "t", ";", 8'h00, 8'h00},
        '{"&", "q", "u", "o", "t", ";"},
        '{"&", "n", "b", "s", "p", ";"}
    };
    localparam fill_t EntLen [EntCount]     = '{3'd5, 3'd4, 3'd4, 3'd6, 3'd6};
    localparam byte_t EntDecoded [EntCount] = '{"&", ">", "<", 8'h22, 8'h00};
    localparam logic  EntEmits [EntCount]   = '{1'b1, 1'b1, 1'b1, 1'b1, 1'b0};

    // One candidate result byte from the step unit
    typedef struct packed {
        logic  valid;
        byte_t data;
        logic  last;
    } emit_t;

    // Outcome of matching one byte against the pending entity
    typedef struct packed {
        logic  hit;
        logic  done;
        logic  emits;
        byte_t decoded;
    } ent_res_t;

endpackage
`default_nettype wire

// File: rtl/core/mse_ent_match.sv
// Entity matcher: checks whether a byte extends the held entity prefix.
`default_nettype none
module mse_ent_match (
    input  mse_pkg::fill_t    fill,
    input  mse_pkg::byte_t    hold [mse_pkg::EntHold],
    input  mse_pkg::byte_t    c,
    output mse_pkg::ent_res_t res
);
    import mse_pkg::*;

    logic ok;

    // Scan the table from the back so the first matching entry wins
    always_comb begin
        res = '0;
        ok  = 1'b0;
        for (int k = EntCount - 1; k >= 0; k--) begin
            ok = (fill < EntLen[k]);
            for (int p = 0; p < EntHold; p++) begin
                if ((3'(p) < fill) && (EntText[k][p] != hold[p])) begin
                    ok = 1'b0;
                end
            end
            for (int p = 0; p < EntMaxLen; p++) begin
                if ((fill == 3'(p)) && (EntText[k][p] != c)) begin
                    ok = 1'b0;
                end
            end
            if (ok) begin
                res.hit     = 1'b1;
                res.done    = ((4'(fill) + 4'd1) == 4'(EntLen[k]));
                res.emits   = EntEmits[k];
                res.decoded = EntDecoded[k];
            end
        end
    end

endmodule
`default_nettype wire

// File: rtl/core/mse_seq.sv
// Sequencer: filter state, entity hold buffer and the replay of failed entities.
`default_nettype none
module mse_seq (
    input  wire              aclk,
    input  wire              aresetn,
    input  wire              s_tvalid,
    output logic             s_tready,
    input  mse_pkg::kind_t   s_kind,
    input  mse_pkg::byte_t   s_byte,
    input  mse_pkg::occ_t    target,
    output mse_pkg::emit_t   emit,
    input  wire              emit_rdy
);
    import mse_pkg::*;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_EXEC   = 2'd1;
    localparam logic [1:0] S_REPLAY = 2'd2;

    logic [1:0] state_reg, state_next;
    kind_t      kind_reg, kind_next;
    byte_t      byte_reg, byte_next;
    logic       tag_reg, tag_next;
    logic       sel_reg, sel_next;
    occ_t       count_reg, count_next;
    fill_t      fill_reg, fill_next;
    byte_t      hold_reg [EntHold];
    byte_t      hold_next [EntHold];
    logic       lwn_reg, lwn_next;
    bidx_t      idx_reg, idx_next;

    ent_res_t   ent;
    logic       adv;
    logic       tag_now;
    logic       fin_emits;
    occ_t       count_inc;

    mse_ent_match u_match (
        .fill (fill_reg),
        .hold (hold_reg),
        .c    (byte_reg),
        .res  (ent)
    );

    // The final step after a replay emits unless it opens a tag or an entity
    assign fin_emits = (kind_reg == KIND_CHUNK_END) ||
                       ((byte_reg != CH_LT) && (byte_reg != CH_AMP));
    assign tag_now   = tag_reg | (byte_reg == CH_LT);
    assign count_inc = (count_reg == 16'hFFFF) ? count_reg : count_reg + 16'd1;
    assign s_tready  = (state_reg == S_IDLE);
    // Hold every register while a result waits for the output register
    assign adv       = !emit.valid || emit_rdy;

    // Work out one step of the current item
    always_comb begin
        state_next = state_reg;
        kind_next  = kind_reg;
        byte_next  = byte_reg;
        tag_next   = tag_reg;
        sel_next   = sel_reg;
        count_next = count_reg;
        fill_next  = fill_reg;
        hold_next  = hold_reg;
        lwn_next   = lwn_reg;
        idx_next   = idx_reg;
        emit       = '0;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    kind_next  = s_kind;
                    byte_next  = s_byte;
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                state_next = S_IDLE;
                case (kind_reg)
                    KIND_TEXT: begin
                        if ((fill_reg != 3'd0) && ent.hit) begin
                            if (ent.done) begin
                                fill_next = 3'd0;
                                if (ent.emits) begin
                                    emit.valid = sel_reg;
                                    emit.data  = ent.decoded;
                                    emit.last  = 1'b1;
                                    lwn_next   = 1'b0;
                                end
                            end else begin
                                hold_next[fill_reg] = byte_reg;
                                fill_next           = fill_reg + 3'd1;
                            end
                        end else if (fill_reg != 3'd0) begin
                            idx_next   = '0;
                            state_next = S_REPLAY;
                        end else begin
                            // Plain byte outside any entity
                            if (!tag_now) begin
                                if (byte_reg == CH_AMP) begin
                                    hold_next[0] = byte_reg;
                                    fill_next    = 3'd1;
                                end else if (!((byte_reg == CH_NL) && lwn_reg)) begin
                                    emit.valid = sel_reg;
                                    emit.data  = byte_reg;
                                    emit.last  = 1'b1;
                                    lwn_next   = (byte_reg == CH_NL);
                                end
                            end
                            tag_next = tag_now && (byte_reg != CH_GT);
                        end
                    end
                    KIND_CHUNK_END: begin
                        if (fill_reg != 3'd0) begin
                            idx_next   = '0;
                            state_next = S_REPLAY;
                        end else begin
                            tag_next   = 1'b0;
                            lwn_next   = 1'b0;
                            emit.valid = sel_reg;
                            emit.data  = CH_NL;
                            emit.last  = 1'b1;
                        end
                    end
                    KIND_ELEM_START: begin
                        count_next = count_inc;
                        if (count_inc == target) begin
                            sel_next = 1'b1;
                        end
                    end
                    default: begin
                        sel_next = 1'b0;
                    end
                endcase
            end
            S_REPLAY: begin
                // Emit the held bytes as text, the ampersand first
                emit.valid = sel_reg;
                emit.data  = (idx_reg == 3'd0) ? CH_AMP : hold_reg[idx_reg];
                emit.last  = (idx_reg == (fill_reg - 3'd1)) && !fin_emits;
                lwn_next   = 1'b0;
                idx_next   = idx_reg + 3'd1;
                if (idx_reg == (fill_reg - 3'd1)) begin
                    fill_next  = 3'd0;
                    state_next = S_EXEC;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            tag_reg   <= 1'b0;
            sel_reg   <= 1'b0;
            count_reg <= '0;
            fill_reg  <= '0;
            lwn_reg   <= 1'b0;
        end else if (adv) begin
            state_reg <= state_next;
            tag_reg   <= tag_next;
            sel_reg   <= sel_next;
            count_reg <= count_next;
            fill_reg  <= fill_next;
            lwn_reg   <= lwn_next;
        end
    end

    // Payload: item, hold buffer and replay position
    always_ff @(posedge aclk) begin
        if (adv) begin
            kind_reg <= kind_next;
            byte_reg <= byte_next;
            hold_reg <= hold_next;
            idx_reg  <= idx_next;
        end
    end

endmodule
`default_nettype wire

// File: rtl/core/markup_strip_entity_decode.sv
// Top level of the markup stripping and entity decoding block.
// Text bytes, chunk ends and selected element start and end events enter on the
// s_ stream, one item at a time; decoded bytes leave on the m_ stream, with
// m_tlast on the final byte that an item causes. An item that causes no byte
// yields no transfer. An item is first taken into the item registers, then handled
// in the shared step unit, which applies tag, entity, newline and element logic.
// When a text byte or a chunk end abandons a pending entity, the step unit replays
// the held bytes first, one by one (the ampersand and up to four more), then
// takes one more step for the item itself. A byte waits in the output register
// until taken, and the step unit holds while that register is full and not being
// drained. The occurrence register is to be written on the cfg_ channel only while
// the block is idle; the block itself does not enforce this. Reset sets it to one.
// There is no clearing pass after reset.
`default_nettype none
`include "assert_macros.svh"
module markup_strip_entity_decode (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [7:0]  s_tdata,   // data_byte
    input  wire  [1:0]  s_tuser,   // kind
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [7:0]  m_tdata,   // out_byte
    output logic        m_tlast,   // last
    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire  [15:0] cfg_data   // target_occurrence
);
    import mse_pkg::*;

    occ_t  target_reg;
    emit_t emit;
    logic  emit_rdy;
    logic  m_tvalid_reg;
    byte_t m_tdata_reg;
    logic  m_tlast_reg;

    // Occurrence register
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_reg <= 16'd1;
        end else if (cfg_valid) begin
            target_reg <= cfg_data;
        end
    end

    mse_seq u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_kind   (s_tuser),
        .s_byte   (s_tdata),
        .target   (target_reg),
        .emit     (emit),
        .emit_rdy (emit_rdy)
    );

    // Output register: load a new item when empty or being drained
    assign emit_rdy = !m_tvalid_reg || m_tready;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (emit.valid && emit_rdy) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit.valid && emit_rdy) begin
            m_tdata_reg <= emit.data;
            m_tlast_reg <= emit.last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    `ASSERT_RST(a_no_take_while_busy, aclk, aresetn, emit.valid |-> !s_tready, "item taken while busy")
    `ASSERT_RST(a_emit_lands, aclk, aresetn, (emit.valid && emit_rdy) |=> m_tvalid, "result lost")
    `ASSERT_CLK(a_reset_values, aclk, $past(!aresetn) |-> ((target_reg == 16'd1) && !m_tvalid_reg), "bad reset")

endmodule
`default_nettype wire
